FILE: src/ptm_pkg.sv
// Package for the packet throughput meter: constants, word types, control types.
`default_nettype none

package ptm_pkg;

    localparam int TIME_BITS  = 64;
    localparam int PKT_W      = 16;
    localparam int BYTES_W    = 48;
    localparam int CNT_W      = 32;
    localparam int RATE_W     = 31;
    localparam int CFG_IVL_W  = 16;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_LSB = 3;

    localparam int MUL_W  = 20;
    localparam int HALF_W = BYTES_W / 2;
    localparam int PROD_W = HALF_W + MUL_W;
    localparam int NUM_W  = BYTES_W + MUL_W;
    localparam int HIGH_W = NUM_W - RATE_W;
    localparam int CMP_W  = ((HIGH_W > TIME_BITS) ? HIGH_W : TIME_BITS) + 1;
    localparam int REM_W  = TIME_BITS + 1;
    localparam int ITER_W = $clog2(RATE_W);

    localparam logic [MUL_W-1:0]     USEC_PER_SEC = MUL_W'(1000000);
    localparam logic [TIME_BITS-1:0] ZERO_ELAPSED = TIME_BITS'(1000);
    localparam logic [RATE_W-1:0]    RATE_MAX     = '1;
    localparam logic [ITER_W-1:0]    DIV_LAST     = ITER_W'(RATE_W - 1);

    localparam logic [CFG_IVL_W-1:0] IVL_RESET = CFG_IVL_W'(10);

    typedef enum logic [1:0] {
        CFG_INTERVAL_PACKETS = 2'd0,
        CFG_INSTANT_ENABLE   = 2'd1,
        CFG_CONN_START_US    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [PKT_W-1:0]   pkt_bytes;
        logic [63:0]        now_us;
        logic [BYTES_W-1:0] total_bytes;
    } in_word_t;

    typedef struct packed {
        logic              interval_valid;
        logic [RATE_W-1:0] interval_rate;
        logic [RATE_W-1:0] average_rate;
        logic              point_valid;
        logic [RATE_W-1:0] point_rate;
    } out_word_t;

    typedef struct packed {
        logic [CFG_IVL_W-1:0] interval_packets;
        logic                 instant_enable;
        logic [63:0]          conn_start_us;
    } cfg_t;

    typedef enum logic [1:0] {
        SEL_INTERVAL,
        SEL_AVERAGE,
        SEL_POINT
    } div_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_LOAD,
        ST_SUM,
        ST_CHECK,
        ST_STEP,
        ST_STORE,
        ST_FINISH
    } ptm_state_t;

    typedef struct packed {
        logic     capture;
        logic     div_load;
        logic     div_sum;
        logic     div_check;
        logic     div_step;
        logic     div_store;
        div_sel_t sel;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic started;
        logic zero_bytes;
        logic close;
        logic instant;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: src/ptm_cfg.sv
// Configuration register block with APB-style access.
`default_nettype none

module ptm_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ptm_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [ptm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [ptm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output ptm_pkg::cfg_t                       cfg
);
    import ptm_pkg::*;

    logic [CFG_IVL_W-1:0] interval_packets_reg;
    logic                 instant_enable_reg;
    logic [63:0]          conn_start_us_reg;
    logic                 wr_en;
    cfg_reg_t             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_packets_reg <= IVL_RESET;
            instant_enable_reg   <= 1'b0;
            conn_start_us_reg    <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                CFG_INTERVAL_PACKETS: interval_packets_reg <= pwdata[CFG_IVL_W-1:0];
                CFG_INSTANT_ENABLE:   instant_enable_reg   <= pwdata[0];
                CFG_CONN_START_US:    conn_start_us_reg    <= pwdata;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            CFG_INTERVAL_PACKETS: prdata = CFG_DATA_W'(interval_packets_reg);
            CFG_INSTANT_ENABLE:   prdata = CFG_DATA_W'(instant_enable_reg);
            CFG_CONN_START_US:    prdata = conn_start_us_reg;
            default:              prdata = '0;
        endcase
    end

    assign cfg.interval_packets = interval_packets_reg;
    assign cfg.instant_enable   = instant_enable_reg;
    assign cfg.conn_start_us    = conn_start_us_reg;

endmodule

`default_nettype wire

FILE: src/ptm_ctrl.sv
// Sequencing controller: packet decision, divider steps, result word handoff.
`default_nettype none

module ptm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire ptm_pkg::dp_status_t st,
    output ptm_pkg::dp_cmd_t         cmd
);
    import ptm_pkg::*;

    ptm_state_t        state_reg, state_next;
    div_sel_t          sel_reg, sel_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_INTERVAL;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!st.started || st.zero_bytes)
                    state_next = ST_FINISH;
                else if (st.close)
                begin
                    state_next = ST_LOAD;
                    sel_next   = SEL_INTERVAL;
                end
                else if (st.instant)
                begin
                    state_next = ST_LOAD;
                    sel_next   = SEL_POINT;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_LOAD:
                state_next = ST_SUM;
            ST_SUM:
            begin
                state_next = ST_CHECK;
                cnt_next   = '0;
            end
            ST_CHECK:
                state_next = ST_STEP;
            ST_STEP:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = ST_STORE;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_STORE:
            begin
                case (sel_reg)
                    SEL_INTERVAL:
                    begin
                        state_next = ST_LOAD;
                        sel_next   = SEL_AVERAGE;
                    end
                    SEL_AVERAGE:
                    begin
                        if (st.instant)
                        begin
                            state_next = ST_LOAD;
                            sel_next   = SEL_POINT;
                        end
                        else
                            state_next = ST_FINISH;
                    end
                    default:
                        state_next = ST_FINISH;
                endcase
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.sel  = sel_reg;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_LOAD:   cmd.div_load  = 1'b1;
            ST_SUM:    cmd.div_sum   = 1'b1;
            ST_CHECK:  cmd.div_check = 1'b1;
            ST_STEP:   cmd.div_step  = 1'b1;
            ST_STORE:  cmd.div_store = 1'b1;
            ST_FINISH: cmd.finish    = slot_free;
            default:   ;
        endcase
    end

    a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result word raised outside finish");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |-> cnt_reg <= DIV_LAST)
        else $error("divider step count overrun");

    a_point_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE && sel_reg == SEL_POINT) |=> state_reg == ST_FINISH)
        else $error("point rate is not the last division");

    a_capture_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> state_reg == ST_DECIDE)
        else $error("accepted word not decided");

endmodule

`default_nettype wire

FILE: src/ptm_dp.sv
// Datapath: meter state, elapsed time, scaled numerator, restoring divider, result words.
`default_nettype none

module ptm_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ptm_pkg::in_word_t   in_data,
    input  wire ptm_pkg::cfg_t       cfg,
    input  wire ptm_pkg::dp_cmd_t    cmd,
    output ptm_pkg::dp_status_t      st,
    output ptm_pkg::out_word_t       out_data
);
    import ptm_pkg::*;

    // meter state
    logic                 started_reg, started_next;
    logic [TIME_BITS-1:0] interval_start_reg, interval_start_next;
    logic [TIME_BITS-1:0] last_pkt_reg, last_pkt_next;
    logic [CNT_W-1:0]     interval_pkts_reg, interval_pkts_next;
    logic [BYTES_W-1:0]   interval_bytes_reg, interval_bytes_next;

    // payload
    in_word_t             item_reg;
    out_word_t            res_reg;
    out_word_t            out_reg;
    logic [TIME_BITS-1:0] den_reg;
    logic [PROD_W-1:0]    plo_reg;
    logic [PROD_W-1:0]    phi_reg;
    logic [NUM_W-1:0]     num_reg;
    logic                 sat_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [RATE_W-1:0]    low_reg;
    logic [RATE_W-1:0]    q_reg;

    logic [TIME_BITS-1:0] now_t;
    logic [BYTES_W-1:0]   bytes_op;
    logic [TIME_BITS-1:0] from_op;
    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS-1:0] elapsed;
    logic [HIGH_W-1:0]    num_high;
    logic [REM_W-1:0]     trial;
    logic [REM_W-1:0]     trial_sub;
    logic                 trial_ge;
    logic [RATE_W-1:0]    rate_val;
    logic [CNT_W-1:0]     pkts_base;
    logic [BYTES_W-1:0]   bytes_base;

    assign now_t = item_reg.now_us[TIME_BITS-1:0];

    assign st.started    = started_reg;
    assign st.zero_bytes = (item_reg.pkt_bytes == '0);
    assign st.close      = ({1'b0, interval_pkts_reg} + (CNT_W + 1)'(1))
                           >= (CNT_W + 1)'(cfg.interval_packets);
    assign st.instant    = cfg.instant_enable;

    always_comb
    begin
        bytes_op = '0;
        from_op  = '0;
        case (cmd.sel)
            SEL_INTERVAL:
            begin
                bytes_op = interval_bytes_reg;
                from_op  = interval_start_reg;
            end
            SEL_AVERAGE:
            begin
                bytes_op = item_reg.total_bytes;
                from_op  = cfg.conn_start_us[TIME_BITS-1:0];
            end
            SEL_POINT:
            begin
                bytes_op = BYTES_W'(item_reg.pkt_bytes);
                from_op  = last_pkt_reg;
            end
            default:
            begin
                bytes_op = '0;
                from_op  = '0;
            end
        endcase
    end

    assign diff    = now_t - from_op;
    assign elapsed = (diff == '0) ? ZERO_ELAPSED : diff;

    assign num_high  = num_reg[NUM_W-1:RATE_W];
    assign trial     = {rem_reg, low_reg[RATE_W-1]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};
    assign rate_val  = sat_reg ? RATE_MAX : q_reg;

    // divider: numerator bytes*1e6 over elapsed, 31 quotient bits after the overflow check
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_data;
        if (cmd.div_load)
        begin
            den_reg <= elapsed;
            plo_reg <= PROD_W'(bytes_op[HALF_W-1:0]) * PROD_W'(USEC_PER_SEC);
            phi_reg <= PROD_W'(bytes_op[BYTES_W-1:HALF_W]) * PROD_W'(USEC_PER_SEC);
        end
        if (cmd.div_sum)
            num_reg <= NUM_W'(plo_reg) + {phi_reg, {HALF_W{1'b0}}};
        if (cmd.div_check)
        begin
            sat_reg <= CMP_W'(num_high) >= CMP_W'(den_reg);
            rem_reg <= TIME_BITS'(num_high);
            low_reg <= num_reg[RATE_W-1:0];
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            low_reg <= {low_reg[RATE_W-2:0], 1'b0};
            q_reg   <= {q_reg[RATE_W-2:0], trial_ge};
        end
        if (cmd.capture)
            res_reg <= '0;
        else if (cmd.div_store)
        begin
            case (cmd.sel)
                SEL_INTERVAL:
                begin
                    res_reg.interval_valid <= 1'b1;
                    res_reg.interval_rate  <= rate_val;
                end
                SEL_AVERAGE:
                    res_reg.average_rate <= rate_val;
                SEL_POINT:
                begin
                    res_reg.point_valid <= 1'b1;
                    res_reg.point_rate  <= rate_val;
                end
                default: ;
            endcase
        end
        if (cmd.finish)
            out_reg <= res_reg;
    end

    assign out_data = out_reg;

    always_comb
    begin
        started_next        = started_reg;
        interval_start_next = interval_start_reg;
        last_pkt_next       = last_pkt_reg;
        interval_pkts_next  = interval_pkts_reg;
        interval_bytes_next = interval_bytes_reg;
        pkts_base           = interval_pkts_reg;
        bytes_base          = interval_bytes_reg;
        if (cmd.finish)
        begin
            if (!started_reg)
            begin
                started_next        = 1'b1;
                interval_start_next = now_t;
                last_pkt_next       = now_t;
                interval_pkts_next  = CNT_W'(1);
                interval_bytes_next = BYTES_W'(item_reg.pkt_bytes);
            end
            else if (!st.zero_bytes)
            begin
                if (st.close)
                begin
                    interval_start_next = now_t;
                    pkts_base           = '0;
                    bytes_base          = '0;
                end
                last_pkt_next       = now_t;
                interval_pkts_next  = pkts_base + CNT_W'(1);
                interval_bytes_next = bytes_base + BYTES_W'(item_reg.pkt_bytes);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg        <= 1'b0;
            interval_start_reg <= '0;
            last_pkt_reg       <= '0;
            interval_pkts_reg  <= '0;
            interval_bytes_reg <= '0;
        end
        else
        begin
            started_reg        <= started_next;
            interval_start_reg <= interval_start_next;
            last_pkt_reg       <= last_pkt_next;
            interval_pkts_reg  <= interval_pkts_next;
            interval_bytes_reg <= interval_bytes_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/packet_throughput_meter_unit.sv
// Packet throughput meter top level: config block, controller and datapath.
// Each word computes k rates, with k from 0 to 3.
// Each rate costs one pass of the shared restoring divider: load, sum, check, 31 steps, store.
// The result word is raised from the finish state, which holds while an earlier result waits.
// The output register frees the input side: a new word is taken while a result waits.
// Reset: asynchronous, active low; meter state cleared, interval setting back to 10.
`default_nettype none

module packet_throughput_meter_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ptm_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [ptm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [ptm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire ptm_pkg::in_word_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output ptm_pkg::out_word_t                  out_data
);
    import ptm_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t st;

    ptm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ptm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    ptm_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg      (cfg),
        .cmd      (cmd),
        .st       (st),
        .out_data (out_data)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_packet_throughput_meter_unit.sv
// Testbench for the packet throughput meter: register setup, packet words, rate prediction.
`timescale 1ns / 1ps

module tb_packet_throughput_meter_unit;
    import ptm_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_word_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_data;

    packet_throughput_meter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    in_word_t  pending_pkts[$];
    out_word_t expected_rates[$];

    int unsigned tx_idle_pct = 23;
    int unsigned rx_stall_pct = 67;
    logic        hold_off = 1'b0;
    int unsigned mismatches = 0;

    // meter copy: settings and connection state
    logic [CFG_IVL_W-1:0] cfg_ivl = IVL_RESET;
    logic                 cfg_inst = 1'b0;
    logic [63:0]          cfg_start = '0;
    logic                 mtr_started = 1'b0;
    logic [63:0]          ivl_start_us = '0;
    logic [63:0]          last_pkt_us = '0;
    logic [CNT_W-1:0]     ivl_pkts = '0;
    logic [BYTES_W-1:0]   ivl_bytes = '0;

    // stimulus generator state
    logic [63:0]          ts_base = '0;
    logic [BYTES_W-1:0]   tot_base = '0;

    function automatic logic [63:0] span_us(input logic [63:0] from_us, input logic [63:0] to_us);
        logic [63:0] d;
        d = to_us - from_us;
        span_us = (d == 64'd0) ? ZERO_ELAPSED : d;
    endfunction

    function automatic logic [RATE_W-1:0] bytes_per_sec(input logic [63:0] nbytes,
                                                        input logic [63:0] span);
        logic [127:0] q;
        q = ({64'd0, nbytes} * 128'd1000000) / {64'd0, span};
        bytes_per_sec = (q > 128'd2147483647) ? RATE_MAX : q[RATE_W-1:0];
    endfunction

    task automatic predict_rates(input in_word_t w);
        out_word_t r;
        r = '0;
        if (!mtr_started) begin
            mtr_started  = 1'b1;
            ivl_start_us = w.now_us;
            last_pkt_us  = w.now_us;
            ivl_pkts     = 1;
            ivl_bytes    = BYTES_W'(w.pkt_bytes);
        end
        else if (w.pkt_bytes != '0) begin
            if ({32'd0, ivl_pkts} + 64'd1 >= {48'd0, cfg_ivl}) begin
                r.interval_valid = 1'b1;
                r.interval_rate  = bytes_per_sec({16'd0, ivl_bytes}, span_us(ivl_start_us, w.now_us));
                r.average_rate   = bytes_per_sec({16'd0, w.total_bytes},
                                                 span_us(cfg_start, w.now_us));
                ivl_start_us = w.now_us;
                ivl_pkts     = '0;
                ivl_bytes    = '0;
            end
            if (cfg_inst) begin
                r.point_valid = 1'b1;
                r.point_rate  = bytes_per_sec({48'd0, w.pkt_bytes}, span_us(last_pkt_us, w.now_us));
            end
            last_pkt_us = w.now_us;
            ivl_pkts    = ivl_pkts + 1;
            ivl_bytes   = ivl_bytes + BYTES_W'(w.pkt_bytes);
        end
        expected_rates.push_back(r);
    endtask

    task automatic note_field(input string fname, input logic [RATE_W-1:0] exp_v,
                              input logic [RATE_W-1:0] got_v);
        if (got_v !== exp_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d got %0d", $realtime, fname, exp_v, got_v);
        end
    endtask

    task automatic check_word(input out_word_t got);
        out_word_t want;
        if (expected_rates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result word %h", $realtime, got);
        end
        else begin
            want = expected_rates.pop_front();
            note_field("interval_valid", RATE_W'(want.interval_valid), RATE_W'(got.interval_valid));
            note_field("interval_rate", want.interval_rate, got.interval_rate);
            note_field("average_rate", want.average_rate, got.average_rate);
            note_field("point_valid", RATE_W'(want.point_valid), RATE_W'(got.point_valid));
            note_field("point_rate", want.point_rate, got.point_rate);
        end
    endtask

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                predict_rates(in_data);
            if (!in_valid || !in_stall) begin
                if (!hold_off && pending_pkts.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_pkts.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                check_word(out_data);
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << CFG_IDX_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_INTERVAL_PACKETS: cfg_ivl = value[CFG_IVL_W-1:0];
            CFG_INSTANT_ENABLE:   cfg_inst = value[0];
            CFG_CONN_START_US:    cfg_start = value;
            default: ;
        endcase
    endtask

    task automatic set_meter(input logic [15:0] ivl, input logic inst, input logic [63:0] start_us);
        write_reg(CFG_INTERVAL_PACKETS, {48'd0, ivl});
        write_reg(CFG_INSTANT_ENABLE, {63'd0, inst});
        write_reg(CFG_CONN_START_US, start_us);
    endtask

    task automatic queue_pkt(input logic [15:0] nb, input logic [63:0] now_us,
                             input logic [47:0] total);
        in_word_t w;
        w.pkt_bytes   = nb;
        w.now_us      = now_us;
        w.total_bytes = total;
        pending_pkts.push_back(w);
    endtask

    task automatic wait_drained;
        @(negedge clk);
        while (pending_pkts.size() != 0 || in_valid || expected_rates.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // mostly monotonic timestamps and running totals, with jumps, wraps and zero gaps
    task automatic queue_random(input int n);
        int unsigned r;
        logic [15:0] nb;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 10)
                nb = '0;
            else if (r < 18)
                nb = 16'hFFFF;
            else if (r < 35)
                nb = 16'($urandom_range(1, 16));
            else
                nb = 16'($urandom_range(0, 65535));
            r = $urandom_range(99);
            if (r < 10)
                ts_base = ts_base;
            else if (r < 70)
                ts_base = ts_base + 64'($urandom_range(1, 5000));
            else if (r < 85)
                ts_base = ts_base + {32'd0, $urandom};
            else if (r < 91)
                ts_base = {$urandom, $urandom};
            else if (r < 96)
                ts_base = ts_base - 64'($urandom_range(1, 1000));
            else
                ts_base = ts_base + 64'($urandom_range(1, 3));
            if ($urandom_range(99) < 88)
                tot_base = tot_base + 48'(nb);
            else
                tot_base = {16'($urandom), $urandom};
            queue_pkt(nb, ts_base, tot_base);
        end
    endtask

    initial begin
        int unsigned r;
        logic [63:0] start_us;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: interval of 10, no point rate; first packet with zero bytes
        queue_pkt(16'd0, 64'd1000, 48'd0);
        queue_pkt(16'd1500, 64'd1800, 48'd1500);
        queue_pkt(16'd0, 64'd1900, 48'd1500);
        wait_drained();

        set_meter(16'd2, 1'b1, 64'd500);
        queue_pkt(16'd100, 64'd1900, 48'd1600);
        queue_pkt(16'hFFFF, 64'd1900, 48'd67135);
        queue_pkt(16'hFFFF, 64'd1901, 48'd132670);
        queue_pkt(16'd1, 64'd1901 + 64'h100_0000_0000, 48'd132671);
        queue_pkt(16'd777, 64'd600, 48'd133448);
        queue_pkt(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_pkt(16'd4096, 64'd20, 48'd1);
        wait_drained();

        set_meter(16'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_pkt(16'd1, 64'd30, 48'd10);
        queue_pkt(16'hFFFF, 64'd30, 48'hFFFF_FFFF_FFFF);
        queue_pkt(16'd2, 64'd5000, 48'd100);
        queue_pkt(16'd0, 64'd6000, 48'd100);
        wait_drained();

        set_meter(16'hFFFF, 1'b1, 64'd0);
        queue_pkt(16'd1000, 64'd7000, 48'd200);
        queue_pkt(16'hFFFF, 64'd8000, 48'd2000000);
        queue_pkt(16'd1, 64'd8001, 48'd2000001);
        wait_drained();

        ts_base  = 64'd9000;
        tot_base = 48'd2000001;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                tx_idle_pct  = 23;
                rx_stall_pct = 67;
            end
            else if (ph < 4) begin
                tx_idle_pct  = 67;
                rx_stall_pct = 23;
            end
            else begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            r = $urandom_range(99);
            if (r < 70)
                start_us = ts_base - 64'($urandom_range(0, 100000));
            else if (r < 85)
                start_us = '0;
            else
                start_us = {$urandom, $urandom};
            case (ph)
                0: set_meter(16'd1, 1'b1, start_us);
                1: set_meter(16'($urandom_range(2, 12)), 1'($urandom), start_us);
                2: set_meter(16'hFFFF, 1'b1, start_us);
                3: set_meter(16'($urandom_range(1, 8)), 1'b0, start_us);
                4: set_meter(16'd3, 1'b1, start_us);
                default: set_meter(16'($urandom_range(2, 20)), 1'($urandom), start_us);
            endcase
            queue_random(125);
            if (ph == 1) begin
                @(negedge clk);
                while (pending_pkts.size() > 60)
                    @(negedge clk);
                hold_off = 1'b1;
                while (in_valid || expected_rates.size() != 0)
                    @(negedge clk);
                repeat (5) @(negedge clk);
                hold_off = 1'b0;
            end
            wait_drained();
        end

        repeat (120) @(posedge clk);
        if (expected_rates.size() != 0) begin
            mismatches += expected_rates.size();
            $display("%0d expected result words never arrived", expected_rates.size());
        end
        if (mismatches == 0)
            $display("packet_throughput_meter_unit test passed");
        else
            $display("packet_throughput_meter_unit test failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("packet_throughput_meter_unit test failed");
        $finish;
    end

endmodule
